// ===== rtl/puv3d_pkg.sv =====
// Shared constants and types for the perpendicular unit vector block.
`timescale 1ns / 1ps
package puv3d_pkg;
   localparam int IN_WIDTH_DEF = 16;
   localparam int OUT_FRAC_DEF = 15;

   typedef struct packed {
      logic neg;
      logic deg;
   } ctl_type;
endpackage

// ===== rtl/puv3d_if.sv =====
// Item channel interfaces for the input vector pair and the unit normal.
`timescale 1ns / 1ps
interface puv3d_req_if #(parameter int W = puv3d_pkg::IN_WIDTH_DEF);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] ax;
   logic signed [W-1:0] ay;
   logic signed [W-1:0] az;
   logic signed [W-1:0] bx;
   logic signed [W-1:0] by;
   logic signed [W-1:0] bz;
   modport source (output valid, ax, ay, az, bx, by, bz, input ready);
   modport sink (input valid, ax, ay, az, bx, by, bz, output ready);
endinterface

interface puv3d_rsp_if #(parameter int W = puv3d_pkg::OUT_FRAC_DEF + 1);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] nx;
   logic signed [W-1:0] ny;
   logic signed [W-1:0] nz;
   logic                degenerate;
   modport source (output valid, nx, ny, nz, degenerate, input ready);
   modport sink (input valid, nx, ny, nz, degenerate, output ready);
endinterface

// ===== rtl/puv3d_cell.sv =====
// One root-digit cell: tries a single bit of the scaled component.
`timescale 1ns / 1ps
module puv3d_cell #(
   parameter int MW  = 2 * puv3d_pkg::IN_WIDTH_DEF,
   parameter int F   = puv3d_pkg::OUT_FRAC_DEF,
   parameter int BIT = 0
) (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [2*MW+2*F-1:0]       r_i,
   input  logic [2*MW+1:0]           s_i,
   input  logic [2*MW+2*F-1:0]       p_i,
   input  logic [F+2*MW+2:0]         q_i,
   input  logic [F:0]                k_i,
   input  puv3d_pkg::ctl_type        ctl_i,
   output logic [2*MW+2*F-1:0]       r_o,
   output logic [2*MW+1:0]           s_o,
   output logic [2*MW+2*F-1:0]       p_o,
   output logic [F+2*MW+2:0]         q_o,
   output logic [F:0]                k_o,
   output puv3d_pkg::ctl_type        ctl_o
);
   localparam int RW = 2*MW + 2*F;
   localparam int SW = 2*MW + 2;
   localparam int QW = F + 1 + SW;
   localparam int PW = 2*MW + 2*F + 5;
   localparam int KW = F + 1;

   logic [PW-1:0]      trial;
   logic               take;
   logic [RW-1:0]      r_ff;
   logic [SW-1:0]      s_ff;
   logic [RW-1:0]      p_ff, p_in;
   logic [QW-1:0]      q_ff, q_in;
   logic [KW-1:0]      k_ff, k_in;
   puv3d_pkg::ctl_type ctl_ff;

   assign trial = PW'(p_i) + (PW'(q_i) << (BIT + 1)) + (PW'(s_i) << (2 * BIT));
   assign take  = trial <= PW'(r_i);

   always_comb begin
      p_in = p_i;
      q_in = q_i;
      k_in = k_i;
      if (take) begin
         p_in = trial[RW-1:0];
         q_in = q_i + (QW'(s_i) << BIT);
         k_in = k_i | (KW'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         r_ff   <= r_i;
         s_ff   <= s_i;
         p_ff   <= p_in;
         q_ff   <= q_in;
         k_ff   <= k_in;
         ctl_ff <= ctl_i;
      end
   end

   assign r_o   = r_ff;
   assign s_o   = s_ff;
   assign p_o   = p_ff;
   assign q_o   = q_ff;
   assign k_o   = k_ff;
   assign ctl_o = ctl_ff;
endmodule

// ===== rtl/perpendicular_unit_vector_3d.sv =====
// Top level: cross product of two vectors scaled to a unit normal.
//
// Usage: req_chan carries one vector pair (ax..bz) per item, rsp_chan one
// unit normal (nx, ny, nz in signed Q1.OUT_FRAC, truncated toward zero,
// +1.0 held at the largest positive code) plus a degenerate flag that is
// set, with zero components, when the cross product is zero.
// Throughput: one item per cycle unless the receiver stalls. Stages from
// accept to rsp valid: one stage for the products, one for the differences
// and magnitudes, one for the squares, one for the length sum, OUT_FRAC + 1
// root-digit cells per component, and the output register.
// The component root runs as a chain of cells, one result bit per cell,
// each cell working with shifts, wide adds and one compare.
// Reset clears every stage valid bit; no item is in flight afterwards.
// When the receiver stalls the whole chain holds; req ready is low only
// while the output register is full and not being taken.
`timescale 1ns / 1ps
module perpendicular_unit_vector_3d #(
   parameter int IN_WIDTH = puv3d_pkg::IN_WIDTH_DEF,
   parameter int OUT_FRAC = puv3d_pkg::OUT_FRAC_DEF
) (
   input  logic     clock,
   input  logic     reset,
   puv3d_req_if.sink req_chan,
   puv3d_rsp_if.source rsp_chan
);
   localparam int IW  = IN_WIDTH;
   localparam int F   = OUT_FRAC;
   localparam int PRW = 2 * IW;
   localparam int CW  = 2 * IW + 1;
   localparam int MW  = 2 * IW;
   localparam int SW  = 2 * MW + 2;
   localparam int RW  = 2 * MW + 2 * F;
   localparam int QW  = F + 1 + SW;
   localparam int KW  = F + 1;
   localparam int NST = F + 6;

   logic                  enable;
   logic [NST-1:0]        valid_ff;

   logic signed [PRW-1:0] ax_e, ay_e, az_e, bx_e, by_e, bz_e;
   logic signed [PRW-1:0] prod_ff [6];
   logic signed [CW-1:0]  c_w [3];
   logic [MW-1:0]         m_ff [3];
   logic [2:0]            neg2_ff, neg3_ff, neg4_ff;
   logic [2*MW-1:0]       msq_ff [3];
   logic [SW-1:0]         s_ff;
   logic [RW-1:0]         r4_ff [3];
   logic                  deg4_ff;

   logic [RW-1:0]         r_w [3][F+2];
   logic [SW-1:0]         s_w [3][F+2];
   logic [RW-1:0]         p_w [3][F+2];
   logic [QW-1:0]         q_w [3][F+2];
   logic [KW-1:0]         k_w [3][F+2];
   puv3d_pkg::ctl_type    ctl_w [3][F+2];

   logic [KW-1:0]         res_w [3];
   logic [KW-1:0]         n_ff [3];
   logic                  deg_ff;

   assign enable         = !valid_ff[NST-1] || rsp_chan.ready;
   assign req_chan.ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[NST-2:0], req_chan.valid};
      end
   end

   assign ax_e = PRW'(req_chan.ax);
   assign ay_e = PRW'(req_chan.ay);
   assign az_e = PRW'(req_chan.az);
   assign bx_e = PRW'(req_chan.bx);
   assign by_e = PRW'(req_chan.by);
   assign bz_e = PRW'(req_chan.bz);

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff[0] <= ay_e * bz_e;
         prod_ff[1] <= az_e * by_e;
         prod_ff[2] <= az_e * bx_e;
         prod_ff[3] <= ax_e * bz_e;
         prod_ff[4] <= ax_e * by_e;
         prod_ff[5] <= ay_e * bx_e;
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_front
      assign c_w[l] = CW'(prod_ff[2*l]) - CW'(prod_ff[2*l+1]);

      always_ff @(posedge clock) begin
         if (enable) begin
            m_ff[l]    <= c_w[l][CW-1] ? MW'(-c_w[l]) : MW'(c_w[l]);
            neg2_ff[l] <= c_w[l][CW-1];
            msq_ff[l]  <= (2*MW)'(m_ff[l]) * (2*MW)'(m_ff[l]);
            neg3_ff[l] <= neg2_ff[l];
            r4_ff[l]   <= {msq_ff[l], {(2*F){1'b0}}};
            neg4_ff[l] <= neg3_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s_ff    <= SW'(msq_ff[0]) + SW'(msq_ff[1]) + SW'(msq_ff[2]);
         deg4_ff <= (msq_ff[0] == '0) && (msq_ff[1] == '0) && (msq_ff[2] == '0);
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign r_w[l][0]       = r4_ff[l];
      assign s_w[l][0]       = s_ff;
      assign p_w[l][0]       = '0;
      assign q_w[l][0]       = '0;
      assign k_w[l][0]       = '0;
      assign ctl_w[l][0].neg = neg4_ff[l];
      assign ctl_w[l][0].deg = deg4_ff;

      for (genvar j = 0; j <= F; j++) begin : g_cell
         puv3d_cell #(.MW(MW), .F(F), .BIT(F - j)) u_cell (
            .clock  (clock),
            .enable (enable),
            .r_i    (r_w[l][j]),
            .s_i    (s_w[l][j]),
            .p_i    (p_w[l][j]),
            .q_i    (q_w[l][j]),
            .k_i    (k_w[l][j]),
            .ctl_i  (ctl_w[l][j]),
            .r_o    (r_w[l][j+1]),
            .s_o    (s_w[l][j+1]),
            .p_o    (p_w[l][j+1]),
            .q_o    (q_w[l][j+1]),
            .k_o    (k_w[l][j+1]),
            .ctl_o  (ctl_w[l][j+1])
         );
      end

      always_comb begin
         if (ctl_w[l][F+1].deg) begin
            res_w[l] = '0;
         end else if (ctl_w[l][F+1].neg) begin
            res_w[l] = KW'(-k_w[l][F+1]);
         end else if (k_w[l][F+1][KW-1]) begin
            res_w[l] = {1'b0, {(KW-1){1'b1}}};
         end else begin
            res_w[l] = k_w[l][F+1];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            n_ff[l] <= res_w[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         deg_ff <= ctl_w[0][F+1].deg;
      end
   end

   assign rsp_chan.valid      = valid_ff[NST-1];
   assign rsp_chan.nx         = n_ff[0];
   assign rsp_chan.ny         = n_ff[1];
   assign rsp_chan.nz         = n_ff[2];
   assign rsp_chan.degenerate = deg_ff;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && deg_ff |-> n_ff[0] == '0 && n_ff[1] == '0 && n_ff[2] == '0)
      else $error("degenerate item with nonzero components");

   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !deg_ff |-> n_ff[0] != '0 || n_ff[1] != '0 || n_ff[2] != '0)
      else $error("unit normal with all components zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> valid_ff == '0)
      else $error("stage valid set after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !enable |=> valid_ff == $past(valid_ff))
      else $error("pipeline moved while stalled");
endmodule

// ===== tb/perpendicular_unit_vector_3d_tb.sv =====
// Testbench for the perpendicular unit vector block: random and directed vector pairs.
`timescale 1ns / 1ps
module perpendicular_unit_vector_3d_tb;
   localparam int IW = puv3d_pkg::IN_WIDTH_DEF;
   localparam int OF = puv3d_pkg::OUT_FRAC_DEF;
   localparam int OW = OF + 1;
   localparam int LATENCY = OF + 6;
   localparam int IDLE_LIMIT = 5000;
   localparam int N_RANDOM = 1650;

   typedef struct {
      logic signed [OW-1:0] nx;
      logic signed [OW-1:0] ny;
      logic signed [OW-1:0] nz;
      logic                 degenerate;
   } normal_type;

   // Integer root of c*c*2^(2*OF)/S, truncated toward zero, with +1.0 held.
   function automatic logic [OW-1:0] scale_component(longint c, logic [127:0] sum_sq);
      logic [127:0] mag, rhs, lhs;
      logic [OW:0] k, t;
      int b;
      mag = (c < 0) ? -c : c;
      rhs = (mag * mag) << (2 * OF);
      k = '0;
      for (b = OF; b >= 0; b--) begin
         t = k | ({{OW{1'b0}}, 1'b1} << b);
         lhs = t * t * sum_sq;
         if (lhs <= rhs) k = t;
      end
      if (c >= 0) begin
         if (k > (OW+1)'((1 << OF) - 1)) k = (OW+1)'((1 << OF) - 1);
         return k[OW-1:0];
      end
      return -k[OW-1:0];
   endfunction

   function automatic normal_type unit_normal(logic signed [IW-1:0] ax, ay, az, bx, by, bz);
      normal_type n;
      longint cx, cy, cz;
      logic [127:0] s;
      cx = longint'(ay) * bz - longint'(az) * by;
      cy = longint'(az) * bx - longint'(ax) * bz;
      cz = longint'(ax) * by - longint'(ay) * bx;
      if (cx == 0 && cy == 0 && cz == 0) begin
         n = '{0, 0, 0, 1'b1};
         return n;
      end
      s = 128'(cx * cx) + 128'(cy * cy) + 128'(cz * cz);
      n.nx = scale_component(cx, s);
      n.ny = scale_component(cy, s);
      n.nz = scale_component(cz, s);
      n.degenerate = 1'b0;
      return n;
   endfunction

   class normal_scoreboard;
      normal_type pending[$];
      int errors = 0;

      function void note_pair(logic signed [IW-1:0] ax, ay, az, bx, by, bz);
         pending.push_back(unit_normal(ax, ay, az, bx, by, bz));
      endfunction

      function void check_normal(normal_type got);
         normal_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected normal %0d %0d %0d %0b",
               got.nx, got.ny, got.nz, got.degenerate);
            return;
         end
         e = pending.pop_front();
         if (got.nx !== e.nx || got.ny !== e.ny || got.nz !== e.nz
             || got.degenerate !== e.degenerate) begin
            errors++;
            if (errors <= 10) $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
               e.nx, e.ny, e.nz, e.degenerate, got.nx, got.ny, got.nz, got.degenerate);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   normal_scoreboard board;
   int idle_cycles = 0;
   int sender_quiet = 0;
   int receiver_quiet = 0;
   bit timed_out = 0;
   bit hold_off = 0;

   puv3d_req_if #(IW) req_chan ();
   puv3d_rsp_if #(OW) rsp_chan ();

   perpendicular_unit_vector_3d u_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source));

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      {req_chan.ax, req_chan.ay, req_chan.az, req_chan.bx, req_chan.by, req_chan.bz} = '0;
      rsp_chan.ready = 1'b0;
      board = new();
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         board.note_pair(req_chan.ax, req_chan.ay, req_chan.az,
                         req_chan.bx, req_chan.by, req_chan.bz);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_normal('{rsp_chan.nx, rsp_chan.ny, rsp_chan.nz, rsp_chan.degenerate});
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else if (hold_off)
         rsp_chan.ready <= 1'b0;
      else if (receiver_quiet > 0)
         rsp_chan.ready <= 1'b1;
      else
         rsp_chan.ready <= ($urandom_range(99) >= 18);
   end

   initial begin
      repeat (600) @(posedge clock);
      hold_off = 1;
      repeat (300) @(posedge clock);
      hold_off = 0;
   end

   task automatic send_pair(logic signed [IW-1:0] ax, ay, az, bx, by, bz);
      while (sender_quiet == 0 && $urandom_range(99) < 18) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      {req_chan.ax, req_chan.ay, req_chan.az} <= {ax, ay, az};
      {req_chan.bx, req_chan.by, req_chan.bz} <= {bx, by, bz};
      do @(posedge clock); while (!req_chan.ready);
      if (sender_quiet > 0) sender_quiet--;
   endtask

   function automatic logic signed [IW-1:0] pick_value();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return IW'($signed($urandom_range(8)) - 4);
         default: return IW'($urandom());
      endcase
   endfunction

   task automatic run_stimulus();
      logic signed [IW-1:0] v[6];
      int k;
      logic signed [IW-1:0] mn, mx;
      mn = 16'sh8000;
      mx = 16'sh7fff;
      send_pair(0, 0, 0, 0, 0, 0);
      send_pair(1, 2, 3, 0, 0, 0);
      send_pair(3, -5, 7, 6, -10, 14);
      send_pair(1, 0, 0, 0, 1, 0);
      send_pair(0, 1, 0, 1, 0, 0);
      send_pair(0, 0, 1, 1, 0, 0);
      send_pair(0, 1, 0, 0, 0, 1);
      send_pair(mn, mn, mn, mx, mx, mx);
      send_pair(mn, 0, 0, 0, mn, 0);
      send_pair(mx, 0, 0, 0, mn, 0);
      send_pair(mn, mx, mn, mx, mn, mx);
      send_pair(mx, mx, 0, mn, mx, 0);
      send_pair(1, 1, 0, 1, 2, 0);
      send_pair(-1, -1, -1, 1, 1, 1);
      send_pair(mn, mn, mn, mn, mn, mn);
      send_pair(mx, mn, 1, -1, mx, mn);
      send_pair(3, 4, 0, 0, 0, 5);
      sender_quiet = 200;
      receiver_quiet = 200;
      for (k = 0; k < N_RANDOM; k++) begin
         foreach (v[i]) v[i] = ($urandom_range(3) == 0) ? pick_value() : IW'($urandom());
         if ($urandom_range(19) == 0) begin
            v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
         end
         send_pair(v[0], v[1], v[2], v[3], v[4], v[5]);
         if (receiver_quiet > 0) receiver_quiet--;
      end
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_stimulus();
      while (board.pending.size() != 0 && !timed_out) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (timed_out) begin
         $display("status: fail");
      end else if (board.errors == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("status: fail");
         $finish;
      end
   end
endmodule
